@@ rtl/btks_pkg.sv @@
// Shared types and constants of the balanced top-k score selector.
// Depends on nothing; the controller, datapath, top level and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package btks_pkg;

    // Field widths
    localparam int SCORE_W   = 16;
    localparam int IDX_W     = 16;
    localparam int BOUND_W   = 15;
    localparam int SIZE_W    = 5;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Most entries of one polarity that a drain emits
    localparam int MAX_SIDE = 16;

    // Register reset values: 0.5 and 1.0 in Q3.12, ten slots
    localparam logic [BOUND_W-1:0] LOWER_RST = 15'd2048;
    localparam logic [BOUND_W-1:0] UPPER_RST = 15'd4096;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 5'd10;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_DRAIN  = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1,
        REG_SIZE  = 2'd2
    } cfg_reg_t;

    // One heap slot
    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          idx;
        logic signed [SCORE_W-1:0] val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ROOT,
        ST_SIFT,
        ST_CNT,
        ST_CNT_LAST,
        ST_CAP,
        ST_EMPTY,
        ST_W_RD,
        ST_W_POS,
        ST_W_NEG,
        ST_W_NEXT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic rd_root;
        logic root;
        logic sift;
        logic cnt_start;
        logic cnt_rd;
        logic cap_load;
        logic walk_rd;
        logic walk_dec;
        logic emit_pos;
        logic emit_neg;
        logic emit_none;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             keep;
        logic             sift_stop;
        logic             cnt_done;
        logic             cap_zero;
        logic             pos_emit;
        logic             neg_emit;
        logic             rem_zero;
        logic             out_free;
    } dp_status_t;

    // True when a is strictly weaker than b for the given polarity
    function automatic logic weaker(input entry_t a, input entry_t b, input logic neg);
        return neg ? (a.val > b.val) : (a.val < b.val);
    endfunction

endpackage

`default_nettype wire

@@ rtl/btks_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module btks_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ rtl/btks_ctrl.sv @@
// Controller of the selector: sequences insert, clear and drain.
// Depends on btks_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module btks_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire btks_pkg::dp_status_t status,
    output btks_pkg::dp_cmd_t         cmd
);
    import btks_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.action)
                    ACT_INSERT:
                    begin
                        if (status.keep)
                        begin
                            cmd.rd_root = 1'b1;
                            state_next  = ST_ROOT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    ACT_DRAIN:
                    begin
                        cmd.cnt_start = 1'b1;
                        state_next    = ST_CNT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ROOT:
            begin
                cmd.root   = 1'b1;
                state_next = ST_SIFT;
            end
            ST_SIFT:
            begin
                cmd.sift = 1'b1;
                if (status.sift_stop)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CNT:
            begin
                cmd.cnt_rd = 1'b1;
                if (status.cnt_done)
                begin
                    state_next = ST_CNT_LAST;
                end
            end
            ST_CNT_LAST:
            begin
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                cmd.cap_load = 1'b1;
                state_next   = status.cap_zero ? ST_EMPTY : ST_W_RD;
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_W_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = ST_W_POS;
            end
            ST_W_POS:
            begin
                if (!status.pos_emit)
                begin
                    state_next = ST_W_NEG;
                end
                else if (status.out_free)
                begin
                    cmd.emit_pos = 1'b1;
                    state_next   = ST_W_NEG;
                end
            end
            ST_W_NEG:
            begin
                if (!status.neg_emit)
                begin
                    state_next = ST_W_NEXT;
                end
                else if (status.out_free)
                begin
                    cmd.emit_neg = 1'b1;
                    state_next   = ST_W_NEXT;
                end
            end
            ST_W_NEXT:
            begin
                if (status.rem_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.walk_dec = 1'b1;
                    state_next   = ST_W_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A word is only loaded into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pos || cmd.emit_neg || cmd.emit_none) |-> status.out_free)
        else $error("emit into a busy output register");

    // At most one word per cycle
    a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_pos, cmd.emit_neg, cmd.emit_none}))
        else $error("more than one emit in a cycle");

endmodule

`default_nettype wire

@@ rtl/btks_dp.sv @@
// Datapath of the selector: config registers, both heap RAMs, sift unit,
// drain counters and output register. Depends on btks_pkg and btks_ram.
`timescale 1ns / 1ps
`default_nettype none

module btks_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire btks_pkg::dp_cmd_t                 cmd,
    output btks_pkg::dp_status_t                   status,
    input  wire logic                              cfg_valid,
    input  wire logic [btks_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [btks_pkg::BOUND_W-1:0]      cfg_data,
    input  wire logic [btks_pkg::ACT_W-1:0]        action,
    input  wire logic [btks_pkg::IDX_W-1:0]        item_index,
    input  wire logic signed [btks_pkg::SCORE_W-1:0] score,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [btks_pkg::IDX_W-1:0]             sel_index,
    output logic                                   sel_negative,
    output logic signed [btks_pkg::SCORE_W-1:0]    sel_score,
    output logic                                   none_selected,
    output logic                                   last
);
    import btks_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = IW + 2;
    localparam int NW = $clog2(CAPACITY + 1);

    // Config registers
    logic [BOUND_W-1:0] lower_reg;
    logic [BOUND_W-1:0] upper_reg;
    logic [SIZE_W-1:0]  size_reg;

    // Latched input word
    logic [ACT_W-1:0]          act_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic                      pol_reg;

    // Heap storage and slot valid flags
    logic [CAPACITY-1:0] ok_pos_reg;
    logic [CAPACITY-1:0] ok_neg_reg;
    logic                oka_p_reg;
    logic                okb_p_reg;
    logic                oka_n_reg;
    logic                okb_n_reg;
    logic [ENTRY_W-1:0]  rda_p;
    logic [ENTRY_W-1:0]  rdb_p;
    logic [ENTRY_W-1:0]  rda_n;
    logic [ENTRY_W-1:0]  rdb_n;
    logic                re;
    logic [CW-1:0]       addr_a_full;
    logic [CW-1:0]       addr_b_full;
    logic [IW-1:0]       addr_a;
    logic [IW-1:0]       addr_b;
    logic                we_p;
    logic                we_n;
    entry_t              wdata;

    // Sift unit
    entry_t              x_reg;
    logic [IW-1:0]       cur_reg;
    entry_t              ea_p;
    entry_t              eb_p;
    entry_t              ea_n;
    entry_t              eb_n;
    entry_t              ea;
    entry_t              eb;
    entry_t              cand;
    entry_t              root_new;
    entry_t              child;
    logic [CW-1:0]       l_full;
    logic [CW-1:0]       r_full;
    logic [CW-1:0]       child_full;
    logic [CW-1:0]       cl_full;
    logic [CW-1:0]       cr_full;
    logic                l_in;
    logic                r_in;
    logic                r_better;
    logic                desc;

    // Drain counters
    logic [IW-1:0]       i_reg;
    logic                acc_en_reg;
    logic [NW-1:0]       pc_reg;
    logic [NW-1:0]       nc_reg;
    logic [NW-1:0]       rem_p_reg;
    logic [NW-1:0]       rem_n_reg;
    logic [NW-1:0]       min_cnt;
    logic [NW-1:0]       cap;
    logic [NW-1:0]       n_used;
    logic [CW-1:0]       n_cw;
    logic [CW-1:0]       n_m1;

    // Filter
    logic signed [SCORE_W:0] s_ext;
    logic [SCORE_W:0]        mag;
    logic                    keep;

    // Output register
    logic                      out_valid_reg;
    logic [IDX_W-1:0]          sel_index_reg;
    logic                      sel_negative_reg;
    logic signed [SCORE_W-1:0] sel_score_reg;
    logic                      none_reg;
    logic                      last_reg;
    logic                      out_free;

    // Config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RST;
            upper_reg <= UPPER_RST;
            size_reg  <= SIZE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOWER: lower_reg <= cfg_data;
                REG_UPPER: upper_reg <= cfg_data;
                REG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Slots in use, clamped to 1..CAPACITY
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_used = NW'(1);
        end
        else if (32'(size_reg) > CAPACITY)
        begin
            n_used = NW'(CAPACITY);
        end
        else
        begin
            n_used = NW'(size_reg);
        end
    end

    assign n_cw = CW'(n_used);
    assign n_m1 = n_cw - CW'(1);

    // Input word latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
        end
        else if (cmd.load)
        begin
            act_reg <= action;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg   <= item_index;
            score_reg <= score;
            pol_reg   <= score[SCORE_W-1] || (score == '0);
        end
    end

    // Magnitude window check
    assign s_ext = {score_reg[SCORE_W-1], score_reg};
    assign mag   = s_ext[SCORE_W] ? (SCORE_W+1)'(-s_ext) : (SCORE_W+1)'(s_ext);
    assign keep  = (mag > (SCORE_W+1)'(lower_reg)) && (mag < (SCORE_W+1)'(upper_reg));

    // Gated read data: a slot not written since clear reads as empty
    assign ea_p = oka_p_reg ? entry_t'(rda_p) : '0;
    assign eb_p = okb_p_reg ? entry_t'(rdb_p) : '0;
    assign ea_n = oka_n_reg ? entry_t'(rda_n) : '0;
    assign eb_n = okb_n_reg ? entry_t'(rdb_n) : '0;
    assign ea   = pol_reg ? ea_n : ea_p;
    assign eb   = pol_reg ? eb_n : eb_p;

    // Root decision
    assign cand.valid = 1'b1;
    assign cand.idx   = idx_reg;
    assign cand.val   = score_reg;
    assign root_new   = weaker(ea, cand, pol_reg) ? cand : ea;

    // One sift level: pick the weaker child, left on a tie
    assign l_full     = {1'b0, cur_reg, 1'b1};
    assign r_full     = l_full + CW'(1);
    assign l_in       = l_full < n_cw;
    assign r_in       = r_full < n_cw;
    assign r_better   = r_in && weaker(eb, ea, pol_reg);
    assign child      = r_better ? eb : ea;
    assign child_full = r_better ? r_full : l_full;
    assign desc       = l_in && weaker(child, x_reg, pol_reg);
    assign cl_full    = {1'b0, child_full[IW-1:0], 1'b1};
    assign cr_full    = cl_full + CW'(1);

    // Read address select
    always_comb
    begin
        priority if (cmd.rd_root)
        begin
            addr_a_full = '0;
            addr_b_full = '0;
        end
        else if (cmd.root)
        begin
            addr_a_full = CW'(1);
            addr_b_full = CW'(2);
        end
        else if (cmd.sift)
        begin
            addr_a_full = cl_full;
            addr_b_full = cr_full;
        end
        else
        begin
            addr_a_full = CW'(i_reg);
            addr_b_full = CW'(i_reg);
        end
    end

    assign re     = cmd.rd_root || cmd.root || cmd.sift || cmd.cnt_rd || cmd.walk_rd;
    assign addr_a = (addr_a_full < CW'(CAPACITY)) ? addr_a_full[IW-1:0] : '0;
    assign addr_b = (addr_b_full < CW'(CAPACITY)) ? addr_b_full[IW-1:0] : '0;

    // Write: child moves up, or the held entry settles
    assign wdata = desc ? child : x_reg;
    assign we_p  = cmd.sift && !pol_reg;
    assign we_n  = cmd.sift && pol_reg;

    btks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_pos_ram (
        .clk     (clk),
        .we      (we_p),
        .waddr   (cur_reg),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rda_p),
        .rdata_b (rdb_p)
    );

    btks_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_neg_ram (
        .clk     (clk),
        .we      (we_n),
        .waddr   (cur_reg),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rda_n),
        .rdata_b (rdb_n)
    );

    // Slot valid flags, cleared at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_pos_reg <= '0;
            ok_neg_reg <= '0;
        end
        else if (cmd.clear)
        begin
            ok_pos_reg <= '0;
            ok_neg_reg <= '0;
        end
        else
        begin
            if (we_p)
            begin
                ok_pos_reg[cur_reg] <= 1'b1;
            end
            if (we_n)
            begin
                ok_neg_reg[cur_reg] <= 1'b1;
            end
        end
    end

    // Flags sampled alongside the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oka_p_reg <= 1'b0;
            okb_p_reg <= 1'b0;
            oka_n_reg <= 1'b0;
            okb_n_reg <= 1'b0;
        end
        else if (re)
        begin
            oka_p_reg <= ok_pos_reg[addr_a];
            okb_p_reg <= ok_pos_reg[addr_b];
            oka_n_reg <= ok_neg_reg[addr_a];
            okb_n_reg <= ok_neg_reg[addr_b];
        end
    end

    // Held entry and current slot of the sift
    always_ff @(posedge clk)
    begin
        if (cmd.root)
        begin
            x_reg   <= root_new;
            cur_reg <= '0;
        end
        else if (cmd.sift && desc)
        begin
            cur_reg <= child_full[IW-1:0];
        end
    end

    // Drain: count valid slots, then walk from the top slot down
    assign min_cnt = (pc_reg < nc_reg) ? pc_reg : nc_reg;
    assign cap     = (32'(min_cnt) > MAX_SIDE) ? NW'(MAX_SIDE) : min_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg      <= '0;
            acc_en_reg <= 1'b0;
            pc_reg     <= '0;
            nc_reg     <= '0;
            rem_p_reg  <= '0;
            rem_n_reg  <= '0;
        end
        else
        begin
            acc_en_reg <= cmd.cnt_rd;
            if (cmd.cnt_start)
            begin
                i_reg  <= '0;
                pc_reg <= '0;
                nc_reg <= '0;
            end
            else
            begin
                if (cmd.cnt_rd && !status.cnt_done)
                begin
                    i_reg <= i_reg + IW'(1);
                end
                if (acc_en_reg)
                begin
                    pc_reg <= pc_reg + NW'(ea_p.valid);
                    nc_reg <= nc_reg + NW'(ea_n.valid);
                end
            end
            if (cmd.cap_load)
            begin
                rem_p_reg <= cap;
                rem_n_reg <= cap;
                i_reg     <= n_m1[IW-1:0];
            end
            if (cmd.walk_dec)
            begin
                i_reg <= i_reg - IW'(1);
            end
            if (cmd.emit_pos)
            begin
                rem_p_reg <= rem_p_reg - NW'(1);
            end
            if (cmd.emit_neg)
            begin
                rem_n_reg <= rem_n_reg - NW'(1);
            end
        end
    end

    // Output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_pos || cmd.emit_neg || cmd.emit_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.emit_pos)
        begin
            sel_index_reg    <= ea_p.idx;
            sel_negative_reg <= 1'b0;
            sel_score_reg    <= ea_p.val;
            none_reg         <= 1'b0;
            last_reg         <= (rem_p_reg == NW'(1)) && (rem_n_reg == '0);
        end
        else if (cmd.emit_neg)
        begin
            sel_index_reg    <= ea_n.idx;
            sel_negative_reg <= 1'b1;
            sel_score_reg    <= ea_n.val;
            none_reg         <= 1'b0;
            last_reg         <= (rem_n_reg == NW'(1)) && (rem_p_reg == '0);
        end
        else if (cmd.emit_none)
        begin
            sel_index_reg    <= '0;
            sel_negative_reg <= 1'b0;
            sel_score_reg    <= '0;
            none_reg         <= 1'b1;
            last_reg         <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sel_index     = sel_index_reg;
    assign sel_negative  = sel_negative_reg;
    assign sel_score     = sel_score_reg;
    assign none_selected = none_reg;
    assign last          = last_reg;

    // Status to the controller
    assign status.action    = act_reg;
    assign status.keep      = keep;
    assign status.sift_stop = !desc;
    assign status.cnt_done  = (CW'(i_reg) == n_m1);
    assign status.cap_zero  = (pc_reg == '0) || (nc_reg == '0);
    assign status.pos_emit  = ea_p.valid && (rem_p_reg != '0);
    assign status.neg_emit  = ea_n.valid && (rem_n_reg != '0);
    assign status.rem_zero  = (rem_p_reg == '0) && (rem_n_reg == '0);
    assign status.out_free  = out_free;

    // The sift never writes past the slots in use
    a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sift |-> (CW'(cur_reg) < n_cw))
        else $error("sift slot beyond heap size");

    // A drain starts with the same budget on both sides
    a_rem_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_load |=> (rem_p_reg == rem_n_reg))
        else $error("unbalanced drain budget");

endmodule

`default_nettype wire

@@ rtl/balanced_top_k_score_selector.sv @@
// Insert: accept, decode, root read, then one sift step per heap level visited
// (up to 5 at 16 slots); a rejected score returns to idle after decode.
// Clear: accept and decode. Drain: accept, decode, count the slots in use, then walk
// each slot (read, positive, negative, next), held by output stalls; one word at a time, set by the FSM.
// Reset (rst_n low, asynchronous): heaps empty, bounds 0.5 / 1.0, size 10.
// Top level: joins controller and datapath. Depends on btks_pkg, btks_ctrl, btks_dp.
`timescale 1ns / 1ps
`default_nettype none

module balanced_top_k_score_selector #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [btks_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [btks_pkg::BOUND_W-1:0]        cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [btks_pkg::ACT_W-1:0]          action,
    input  wire logic [btks_pkg::IDX_W-1:0]          item_index,
    input  wire logic signed [btks_pkg::SCORE_W-1:0] score,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [btks_pkg::IDX_W-1:0]               sel_index,
    output logic                                     sel_negative,
    output logic signed [btks_pkg::SCORE_W-1:0]      sel_score,
    output logic                                     none_selected,
    output logic                                     last
);
    import btks_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Config writes are always accepted
    assign cfg_ready = 1'b1;

    btks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    btks_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .item_index    (item_index),
        .score         (score),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sel_index     (sel_index),
        .sel_negative  (sel_negative),
        .sel_score     (sel_score),
        .none_selected (none_selected),
        .last          (last)
    );

endmodule

`default_nettype wire

@@ tb/balanced_top_k_score_selector_test.sv @@
// Testbench for balanced_top_k_score_selector: directed boundary, size and bound cases,
// then random candidate streams under three pacing phases, every drain word checked.
// Depends on btks_pkg and the selector RTL; self-contained otherwise.
`timescale 1ns / 1ps

module balanced_top_k_score_selector_test;
    import btks_pkg::*;

    localparam int SLOTS         = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;

    // Action code the block must ignore
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    // One expected drain word
    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic                      neg;
        logic signed [SCORE_W-1:0] val;
        logic                      none;
        logic                      fin;
    } sel_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [BOUND_W-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [ACT_W-1:0]          action;
    logic [IDX_W-1:0]          item_index;
    logic signed [SCORE_W-1:0] score;
    logic                      out_valid;
    logic                      out_ready;
    logic [IDX_W-1:0]          sel_index;
    logic                      sel_negative;
    logic signed [SCORE_W-1:0] sel_score;
    logic                      none_selected;
    logic                      last;

    // Shadow heaps (side 0 positive, side 1 negative) and register copies
    entry_t             heap_m [2][SLOTS];
    logic [BOUND_W-1:0] lower_m;
    logic [BOUND_W-1:0] upper_m;
    logic [SIZE_W-1:0]  size_m;
    sel_word_t          expected_sel_q [$];
    sel_word_t          seen_w;

    int errors;
    int words_sent;
    int words_checked;
    int drains_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    balanced_top_k_score_selector DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .item_index    (item_index),
        .score         (score),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sel_index     (sel_index),
        .sel_negative  (sel_negative),
        .sel_score     (sel_score),
        .none_selected (none_selected),
        .last          (last)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Heap predictor
    // ---------------------------------------------------------------
    function automatic void heaps_empty();
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                heap_m[s][i] = '0;
            end
        end
    endfunction

    function automatic int slots_used();
        if (size_m == 0)
        begin
            return 1;
        end
        if (size_m > SLOTS)
        begin
            return SLOTS;
        end
        return int'(size_m);
    endfunction

    // Append one expected word at the tail of the queue
    function automatic void queue_word(input sel_word_t w);
        expected_sel_q = {expected_sel_q, w};
    endfunction

    // a is strictly weaker than b; side 1 ranks more negative as stronger
    function automatic bit loses_to(input entry_t a, input entry_t b, input int side);
        if (side == 1)
        begin
            return $signed(a.val) > $signed(b.val);
        end
        return $signed(a.val) < $signed(b.val);
    endfunction

    function automatic void heap_insert(input logic [IDX_W-1:0] idx,
                                        input logic signed [SCORE_W-1:0] sc);
        int     s;
        int     mag;
        int     side;
        int     n;
        int     cur;
        int     l;
        int     r;
        int     m;
        entry_t cand;
        entry_t t;
        s   = int'(sc);
        mag = (s < 0) ? -s : s;
        if (!(mag > int'(lower_m) && mag < int'(upper_m)))
        begin
            return;
        end
        side       = (s > 0) ? 0 : 1;
        n          = slots_used();
        cand.valid = 1'b1;
        cand.idx   = idx;
        cand.val   = sc;
        if (loses_to(heap_m[side][0], cand, side))
        begin
            heap_m[side][0] = cand;
        end
        // sift the root down, left child wins ties
        cur = 0;
        while (1)
        begin
            l = 2 * cur + 1;
            r = 2 * cur + 2;
            m = cur;
            if (l < n && loses_to(heap_m[side][l], heap_m[side][m], side))
            begin
                m = l;
            end
            if (r < n && loses_to(heap_m[side][r], heap_m[side][m], side))
            begin
                m = r;
            end
            if (m == cur)
            begin
                break;
            end
            t                 = heap_m[side][cur];
            heap_m[side][cur] = heap_m[side][m];
            heap_m[side][m]   = t;
            cur               = m;
        end
    endfunction

    // Balanced drain: equal positive and negative counts, last slot first
    function automatic void heap_drain();
        int        n;
        int        pc;
        int        nc;
        int        total;
        int        emitted;
        sel_word_t w;
        n       = slots_used();
        pc      = 0;
        nc      = 0;
        emitted = 0;
        for (int i = 0; i < n; i++)
        begin
            if (heap_m[0][i].valid)
            begin
                pc++;
            end
            if (heap_m[1][i].valid)
            begin
                nc++;
            end
        end
        if (nc > pc)
        begin
            nc = pc;
        end
        if (pc > nc)
        begin
            pc = nc;
        end
        if (pc > MAX_SIDE)
        begin
            pc = MAX_SIDE;
        end
        nc    = pc;
        total = 2 * pc;
        for (int i = n - 1; i >= 0; i--)
        begin
            for (int s = 0; s < 2; s++)
            begin
                if (((s == 0) ? pc : nc) > 0 && heap_m[s][i].valid)
                begin
                    if (s == 0)
                    begin
                        pc--;
                    end
                    else
                    begin
                        nc--;
                    end
                    emitted++;
                    w.idx  = heap_m[s][i].idx;
                    w.neg  = (s == 1);
                    w.val  = heap_m[s][i].val;
                    w.none = 1'b0;
                    w.fin  = (emitted == total);
                    queue_word(w);
                end
            end
        end
        if (total == 0)
        begin
            w      = '0;
            w.none = 1'b1;
            w.fin  = 1'b1;
            queue_word(w);
        end
    endfunction

    function automatic void predict_word(input logic [ACT_W-1:0] act,
                                         input logic [IDX_W-1:0] idx,
                                         input logic signed [SCORE_W-1:0] sc);
        case (act)
            ACT_INSERT: heap_insert(idx, sc);
            ACT_CLEAR:  heaps_empty();
            ACT_DRAIN:
            begin
                drains_sent++;
                heap_drain();
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Send one input word; entered and left at a falling edge
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                             input logic signed [SCORE_W-1:0] sc);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = act;
        item_index = idx;
        score      = sc;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_word(act, idx, sc);
        words_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until no result is owed and any insert still in flight is done
    task automatic settle();
        while (expected_sel_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input int value);
        settle();
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = value[BOUND_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (r)
            REG_LOWER: lower_m = cfg_data;
            REG_UPPER: upper_m = cfg_data;
            REG_SIZE:  size_m  = cfg_data[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input int lo, input int hi, input int sz);
        write_reg(REG_LOWER, lo);
        write_reg(REG_UPPER, hi);
        write_reg(REG_SIZE, sz);
    endtask

    // Receiver pacing
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (expected_sel_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word expected none actual index %h score %h",
                         $time, sel_index, sel_score);
            end
            else
            begin
                seen_w = expected_sel_q.pop_front();
                check_field("sel_index", seen_w.idx, sel_index);
                check_field("sel_negative", 16'(seen_w.neg), 16'(sel_negative));
                check_field("sel_score", seen_w.val, sel_score);
                check_field("none_selected", 16'(seen_w.none), 16'(none_selected));
                check_field("last", 16'(seen_w.fin), 16'(last));
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d words still owed",
                         $time, stall_cycles, expected_sel_q.size());
                $display("balanced_top_k_score_selector: mismatch");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Default bounds: edges of the window, zero and extreme scores, ties, unused action
    task automatic run_boundary_test();
        send_word(ACT_DRAIN, 16'h0000, 16'sd0);
        send_word(ACT_INSERT, 16'h0000, 16'sd2048);
        send_word(ACT_INSERT, 16'hFFFF, 16'sd4096);
        send_word(ACT_INSERT, 16'h0001, 16'sd2049);
        send_word(ACT_INSERT, 16'h0002, 16'sd4095);
        send_word(ACT_INSERT, 16'h0003, -16'sd2049);
        send_word(ACT_INSERT, 16'h0004, -16'sd4095);
        send_word(ACT_INSERT, 16'h0005, 16'sd0);
        send_word(ACT_INSERT, 16'h0006, -16'sd32768);
        send_word(ACT_INSERT, 16'h0007, 16'sd32767);
        send_word(ACT_INSERT, 16'h0008, -16'sd4096);
        send_word(ACT_UNUSED, 16'hFFFF, -16'sd1);
        send_word(ACT_INSERT, 16'h0009, 16'sd3000);
        send_word(ACT_DRAIN, 16'h0000, 16'sd0);
        send_word(ACT_INSERT, 16'h000A, 16'sd3000);
        send_word(ACT_INSERT, 16'h000B, -16'sd3000);
        send_word(ACT_INSERT, 16'h000C, -16'sd3000);
        send_word(ACT_DRAIN, 16'hFFFF, -16'sd1);
        send_word(ACT_CLEAR, 16'h0000, 16'sd0);
        send_word(ACT_DRAIN, 16'h0000, 16'sd0);
    endtask

    // Size zero acts as one slot, sizes above the capacity act as the capacity
    task automatic run_size_limit_test();
        write_reg(REG_SIZE, 0);
        send_word(ACT_INSERT, 16'h0100, 16'sd2500);
        send_word(ACT_INSERT, 16'h0101, 16'sd2600);
        send_word(ACT_INSERT, 16'h0102, 16'sd2400);
        send_word(ACT_INSERT, 16'h0103, -16'sd2500);
        send_word(ACT_DRAIN, 16'h0000, 16'sd0);
        write_reg(REG_SIZE, 31);
        send_word(ACT_INSERT, 16'h0104, -16'sd3500);
        send_word(ACT_INSERT, 16'h0105, 16'sd3500);
        send_word(ACT_DRAIN, 16'h0000, 16'sd0);
    endtask

    // Empty window, then the widest window
    task automatic run_bounds_test();
        set_config(4000, 100, 16);
        send_word(ACT_CLEAR, 16'h0000, 16'sd0);
        send_word(ACT_INSERT, 16'h0200, 16'sd3000);
        send_word(ACT_INSERT, 16'h0201, -16'sd3000);
        send_word(ACT_DRAIN, 16'h0000, 16'sd0);
        set_config(0, 32767, 16);
        send_word(ACT_INSERT, 16'h0202, 16'sd1);
        send_word(ACT_INSERT, 16'h0203, -16'sd1);
        send_word(ACT_INSERT, 16'h0204, 16'sd32767);
        send_word(ACT_INSERT, 16'h0205, -16'sd32767);
        send_word(ACT_INSERT, 16'h0206, -16'sd32768);
        send_word(ACT_DRAIN, 16'h0000, 16'sd0);
    endtask

    // Score mostly inside the current window, with ties and some raw noise
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int lo;
        int hi;
        int mag;
        int pick;
        lo   = int'(lower_m);
        hi   = int'(upper_m);
        pick = $urandom_range(0, 99);
        if (pick < 12 || lo + 1 >= hi)
        begin
            return SCORE_W'($urandom_range(0, 65535));
        end
        if (pick < 32)
        begin
            case ($urandom_range(0, 2))
                0:       mag = lo + 1;
                1:       mag = hi - 1;
                default: mag = (lo + hi) / 2;
            endcase
        end
        else
        begin
            mag = $urandom_range(lo + 1, hi - 1);
        end
        return SCORE_W'($urandom_range(0, 1) ? -mag : mag);
    endfunction

    task automatic random_config();
        int lo;
        int hi;
        int sz;
        int roll;
        roll = $urandom_range(0, 7);
        if (roll < 2)
        begin
            lo = int'(LOWER_RST);
            hi = int'(UPPER_RST);
        end
        else if (roll < 4)
        begin
            lo = 0;
            hi = 32767;
        end
        else if (roll < 7)
        begin
            lo = $urandom_range(0, 16000);
            hi = lo + $urandom_range(2, 16000);
        end
        else
        begin
            lo = $urandom_range(0, 32767);
            hi = $urandom_range(0, 32767);
        end
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            sz = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        end
        else if (roll < 4)
        begin
            sz = 16;
        end
        else
        begin
            sz = $urandom_range(1, 16);
        end
        set_config(lo, hi, sz);
    endtask

    // Three segments, each under a fresh setting and ending in a drain
    task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
        int roll;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < 3; seg++)
        begin
            random_config();
            if ($urandom_range(0, 1))
            begin
                send_word(ACT_CLEAR, IDX_W'($urandom_range(0, 65535)),
                          SCORE_W'($urandom_range(0, 65535)));
            end
            for (int k = 0; k < count / 3 - 1; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                begin
                    send_word(ACT_CLEAR, IDX_W'($urandom_range(0, 65535)),
                              SCORE_W'($urandom_range(0, 65535)));
                end
                else if (roll < 9)
                begin
                    send_word(ACT_DRAIN, IDX_W'($urandom_range(0, 65535)),
                              SCORE_W'($urandom_range(0, 65535)));
                end
                else if (roll < 12)
                begin
                    send_word(ACT_UNUSED, IDX_W'($urandom_range(0, 65535)),
                              SCORE_W'($urandom_range(0, 65535)));
                end
                else
                begin
                    send_word(ACT_INSERT, IDX_W'($urandom_range(0, 65535)), pick_score());
                end
            end
            send_word(ACT_DRAIN, IDX_W'($urandom_range(0, 65535)),
                      SCORE_W'($urandom_range(0, 65535)));
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        errors        = 0;
        words_sent    = 0;
        words_checked = 0;
        drains_sent   = 0;
        stall_cycles  = 0;
        send_idle_pct = 31;
        recv_idle_pct = 71;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        action        = '0;
        item_index    = '0;
        score         = '0;
        out_ready     = 1'b0;
        heaps_empty();
        lower_m = LOWER_RST;
        upper_m = UPPER_RST;
        size_m  = SIZE_RST;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        run_boundary_test();
        run_size_limit_test();
        run_bounds_test();
        run_random_phase(31, 71, 114);
        run_random_phase(71, 31, 114);
        run_random_phase(0, 0, 114);

        while (expected_sel_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d words including %0d drains; checked %0d result words",
                 words_sent, drains_sent, words_checked);
        $display("Covered window edges, empty and full windows, size limits, three pacings");
        if (errors == 0)
        begin
            $display("balanced_top_k_score_selector: match");
        end
        else
        begin
            $display("balanced_top_k_score_selector: mismatch");
        end
        $finish;
    end

endmodule
